FILE: sv/ptc_pkg.sv
// Package: pixel types, register indexes and pipeline constants for the tone curve.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_POINTS_LOW  = 2'd1,
    REG_POINTS_HIGH = 2'd2
  } cfg_reg_t;

  localparam int NUM_PTS   = 8;
  localparam int DIV_STG   = 4;
  // search, multiply, numerator, divider stages, output register
  localparam int LAT       = 3 + DIV_STG + 1;
  localparam logic [3:0]  RST_COUNT = 4'd2;
  localparam logic [63:0] RST_LOW   = 64'h0000_0000_FFFF_0000;
  localparam logic [63:0] RST_HIGH  = 64'h0;

endpackage
`default_nettype wire

FILE: sv/ptc_div.sv
// Pipelined restoring divider: 8-bit quotient, two quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module ptc_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [17:0] num,
  input  wire logic [8:0]  den,
  output logic [7:0]       quo
);
  import ptc_pkg::*;

  logic [17:0] rem_q [DIV_STG];
  logic [8:0]  den_q [DIV_STG];
  logic [7:0]  quo_q [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stage
    logic [17:0] rem_in, rem_mid, rem_out;
    logic [8:0]  den_in;
    logic [7:0]  quo_in, quo_out;
    logic [17:0] trial_hi, trial_lo;

    always_comb begin
      if (s == 0) begin
        rem_in = num;
        den_in = den;
        quo_in = '0;
      end else begin
        rem_in = rem_q[s-1];
        den_in = den_q[s-1];
        quo_in = quo_q[s-1];
      end
      trial_hi = {9'd0, den_in} << (7 - 2*s);
      trial_lo = {9'd0, den_in} << (6 - 2*s);
      quo_out = quo_in;
      rem_mid = rem_in;
      if (rem_in >= trial_hi) begin
        rem_mid = rem_in - trial_hi;
        quo_out[7-2*s] = 1'b1;
      end
      rem_out = rem_mid;
      if (rem_mid >= trial_lo) begin
        rem_out = rem_mid - trial_lo;
        quo_out[6-2*s] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_out;
        den_q[s] <= den_in;
        quo_q[s] <= quo_out;
      end
    end
  end

  assign quo = quo_q[DIV_STG-1];

endmodule
`default_nettype wire

FILE: sv/ptc_lane.sv
// One color lane: segment search, interpolation products, numerator and divide.
`timescale 1ns / 1ps
`default_nettype none
module ptc_lane (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [7:0]   v,
  input  wire logic [3:0]   n,
  input  wire logic [127:0] pts,
  output logic [7:0]        res
);
  import ptc_pkg::*;

  // stage 1: find segment
  logic [2:0] seg;
  logic       run;
  logic [2:0] seg_nx;
  logic       byp_c;
  logic [7:0] bval_c;
  logic [7:0] xa, ya, xb, yb;

  always_comb begin
    seg = '0;
    run = 1'b1;
    for (int k = 1; k < NUM_PTS; k++) begin
      run = run && (4'(k) < n) && (pts[16*k +: 8] < v);
      seg = seg + 3'(run);
    end
    seg_nx = seg + 3'd1;
    xa = pts[{seg, 4'd0} +: 8];
    ya = pts[{seg, 4'd8} +: 8];
    xb = pts[{seg_nx, 4'd0} +: 8];
    yb = pts[{seg_nx, 4'd8} +: 8];
    byp_c  = 1'b1;
    bval_c = v;
    if (n == 4'd0) begin
      bval_c = v;
    end else if ({1'b0, seg} + 4'd1 >= n) begin
      bval_c = pts[{n[2:0] - 3'd1, 4'd8} +: 8];
    end else if (xa > v) begin
      bval_c = pts[15:8];
    end else begin
      byp_c = 1'b0;
    end
  end

  logic       byp1;
  logic [7:0] bv1, v1, x0, y0, x1, y1;
  always_ff @(posedge clk) begin
    if (en) begin
      byp1 <= byp_c;
      bv1  <= bval_c;
      v1   <= v;
      x0   <= xa;
      y0   <= ya;
      x1   <= xb;
      y1   <= yb;
    end
  end

  // stage 2: products
  logic [7:0] dx_c, dv_c;
  logic signed [8:0] dy_c;
  always_comb begin
    dx_c = x1 - x0;
    dv_c = v1 - x0;
    dy_c = $signed({1'b0, y1}) - $signed({1'b0, y0});
  end

  logic               byp2;
  logic [7:0]         bv2, dx2;
  logic signed [17:0] prod2;
  logic [15:0]        base2;
  always_ff @(posedge clk) begin
    if (en) begin
      byp2  <= byp1 || (dx_c == 8'd0);
      bv2   <= byp1 ? bv1 : y0;
      dx2   <= dx_c;
      prod2 <= $signed({1'b0, dv_c}) * dy_c;
      base2 <= y0 * dx_c;
    end
  end

  // stage 3: rounded numerator and divisor
  logic signed [18:0] sum_c;
  logic [16:0]        num_c;
  always_comb begin
    sum_c = $signed({3'b000, base2}) + 19'(prod2);
    num_c = sum_c[18] ? 17'd0 : sum_c[16:0];
  end

  logic        byp3;
  logic [7:0]  bv3;
  logic [17:0] nn3;
  logic [8:0]  dd3;
  always_ff @(posedge clk) begin
    if (en) begin
      byp3 <= byp2;
      bv3  <= bv2;
      nn3  <= {num_c, 1'b0} + {10'd0, dx2};
      dd3  <= {dx2, 1'b0};
    end
  end

  // divider stages, bypass carried alongside
  logic [7:0] quo;
  ptc_div u_div (
    .clk (clk),
    .en  (en),
    .num (nn3),
    .den (dd3),
    .quo (quo)
  );

  logic       byp_d [DIV_STG];
  logic [7:0] bv_d  [DIV_STG];
  always_ff @(posedge clk) begin
    if (en) begin
      byp_d[0] <= byp3;
      bv_d[0]  <= bv3;
      for (int s = 1; s < DIV_STG; s++) begin
        byp_d[s] <= byp_d[s-1];
        bv_d[s]  <= bv_d[s-1];
      end
    end
  end

  assign res = byp_d[DIV_STG-1] ? bv_d[DIV_STG-1] : quo;

endmodule
`default_nettype wire

FILE: sv/piecewise_linear_tone_curve_rgb.sv
// Top level: RGB tone curve with configuration registers and pipeline control.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | to block  | in_valid / in_stall    | ptc_pkg::pix_in_t
//  out     | from block| out_valid / out_stall  | ptc_pkg::pix_out_t
//  cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel enters per cycle unless the pipeline holds; each result passes
// through the search, multiply, numerator, four two-bit divider stages
// and the output register. The whole pipeline advances together and holds
// when the output register is full and stalled; in_stall mirrors that hold.
// rst is synchronous; it clears the valid bits and loads the curve registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_tone_curve_rgb #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ptc_pkg::pix_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ptc_pkg::pix_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [63:0]      cfg_data
);
  import ptc_pkg::*;

  // curve registers
  logic [3:0]  point_count;
  logic [63:0] points_low, points_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= RST_COUNT;
      points_low  <= RST_LOW;
      points_high <= RST_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count <= cfg_data[3:0];
        REG_POINTS_LOW:  points_low  <= cfg_data;
        REG_POINTS_HIGH: points_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp count to the configured limit
  logic [3:0] n_eff;
  assign n_eff = (point_count > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : point_count;

  // advance everything unless a finished result is held at the output
  logic en;
  logic [LAT-1:0] vld;
  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // alpha rides alongside the lanes
  logic [7:0] alpha_q [LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      alpha_q[0] <= in_data.alpha_in;
      for (int s = 1; s < LAT - 1; s++) begin
        alpha_q[s] <= alpha_q[s-1];
      end
    end
  end

  logic [127:0] pts;
  assign pts = {points_high, points_low};

  logic [7:0] r_res, g_res, b_res;

  ptc_lane u_red (
    .clk (clk), .en (en), .v (in_data.red_in), .n (n_eff), .pts (pts), .res (r_res)
  );
  ptc_lane u_green (
    .clk (clk), .en (en), .v (in_data.green_in), .n (n_eff), .pts (pts), .res (g_res)
  );
  ptc_lane u_blue (
    .clk (clk), .en (en), .v (in_data.blue_in), .n (n_eff), .pts (pts), .res (b_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.red_out   <= r_res;
      out_data.green_out <= g_res;
      out_data.blue_out  <= b_res;
      out_data.alpha_out <= alpha_q[LAT-2];
    end
  end

  // accepted transaction lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted transaction missing from first stage");

  // hold only when the output is full and stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("pipeline held without output stall");

  // a held result stays valid
  a_keep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result dropped");

endmodule
`default_nettype wire
